/* src/csu_pkg.sv */
// ----------------------------------------------------------------------------
// csu_pkg: shared types and constants for the CAN signal unpacker
// Beat formats for the command and result ports, and the record passed from
// bit extraction to scaling.
// ----------------------------------------------------------------------------
package csu_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 8;
  localparam int unsigned FRAME_BYTES_MAX = 8;

  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned START_W   = 6;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned FACTOR_W  = 32;
  localparam int unsigned OFFSET_W  = 48;
  localparam int unsigned VALUE_W   = 64;

  typedef struct packed {
    logic [PAYLOAD_W-1:0]       payload;
    logic [START_W-1:0]         start_bit;
    logic [LEN_W-1:0]           length;
    logic                       big_endian;
    logic                       is_signed;
    logic signed [FACTOR_W-1:0] factor;
    logic signed [OFFSET_W-1:0] offset;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] raw_value;
    logic signed [VALUE_W-1:0] phys_value;
    logic                      out_of_frame;
    logic                      saturated;
  } result_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  raw_value;
    logic                       out_of_frame;
    logic signed [FACTOR_W-1:0] factor;
    logic signed [OFFSET_W-1:0] offset;
  } extract_t;

endpackage

/* src/csu_extract.sv */
// ----------------------------------------------------------------------------
// csu_extract: signal bit extraction
// Pulls one Intel or Motorola ordered field out of the payload, clears bits
// beyond the frame, sign-extends and flags a walk that leaves the frame.
// ----------------------------------------------------------------------------
module csu_extract #(
  parameter int unsigned FRAME_BYTES = csu_pkg::FRAME_BYTES_DEF
) (
  input  csu_pkg::item_t    item_i,
  output csu_pkg::extract_t ext_o
);

  localparam int unsigned FrameBits = FRAME_BYTES * 8;
  localparam logic [64:0] FrameMaskW = (65'd1 << FrameBits) - 65'd1;
  localparam logic [63:0] FrameMask = FrameMaskW[63:0];

  logic [6:0]   len;
  logic [63:0]  data;
  logic [63:0]  data_rev;
  logic [5:0]   mot_start;
  logic [7:0]   mot_shift;
  logic [127:0] mot_win;
  logic [127:0] intel_win;
  logic [63:0]  sel;
  logic [63:0]  mask;
  logic [63:0]  raw0;
  logic [5:0]   sign_idx;
  logic         sext;
  logic [7:0]   walk_end;

  assign len  = (item_i.length > 7'd64) ? 7'd64 : item_i.length;
  assign data = item_i.payload & FrameMask;

  // byte reversal turns the Motorola walk into a plain descending bit run
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      data_rev[b*8 +: 8] = data[(7-b)*8 +: 8];
    end
  end

  assign mot_start = {item_i.start_bit[5:3], ~item_i.start_bit[2:0]};
  assign mot_shift = 8'd128 - {2'b00, mot_start} - {1'b0, len};
  assign mot_win   = {data_rev, 64'd0} >> mot_shift;
  assign intel_win = {64'd0, data} >> item_i.start_bit;

  assign sel  = item_i.big_endian ? mot_win[63:0] : intel_win[63:0];
  assign mask = (64'd1 << len) - 64'd1;
  assign raw0 = sel & mask;

  assign sign_idx = len[5:0] - 6'd1;
  assign sext     = item_i.is_signed && (len != 7'd0) && !len[6] && raw0[sign_idx];

  assign walk_end = (item_i.big_endian ? {2'b00, mot_start} : {2'b00, item_i.start_bit})
                  + {1'b0, len};

  always_comb begin
    ext_o.raw_value    = sext ? (raw0 | ~mask) : raw0;
    ext_o.out_of_frame = (len != 7'd0) && (walk_end > 8'(FrameBits));
    ext_o.factor       = item_i.factor;
    ext_o.offset       = item_i.offset;
  end

endmodule

/* src/csu_scale.sv */
// ----------------------------------------------------------------------------
// csu_scale: physical value scaling
// Two-stage pipeline: split 64x32 product into registered partial products,
// then sum with the offset and saturate into the result register.
// ----------------------------------------------------------------------------
module csu_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  csu_pkg::extract_t ext_i,
  output logic              valid_o,
  output csu_pkg::result_t  res_o
);

  localparam logic [63:0] MaxVal = {1'b0, {63{1'b1}}};
  localparam logic [63:0] MinVal = {1'b1, 63'd0};

  logic signed [32:0] raw_lo;
  logic signed [31:0] raw_hi;
  logic signed [64:0] p_lo_d, p_lo_q;
  logic signed [63:0] p_hi_d, p_hi_q;
  logic signed [47:0] offset_q;
  logic [63:0]        raw_q;
  logic               oof_q;
  logic               prod_valid_q;

  logic [97:0]        hi_ext, lo_ext, off_ext, sum;
  logic               sum_fits;
  csu_pkg::result_t   res_d, res_q;
  logic               valid_q;

  assign raw_lo = {1'b0, ext_i.raw_value[31:0]};
  assign raw_hi = ext_i.raw_value[63:32];
  assign p_lo_d = raw_lo * ext_i.factor;
  assign p_hi_d = raw_hi * ext_i.factor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      prod_valid_q <= valid_i;
      valid_q      <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_lo_q   <= p_lo_d;
    p_hi_q   <= p_hi_d;
    offset_q <= ext_i.offset;
    raw_q    <= ext_i.raw_value;
    oof_q    <= ext_i.out_of_frame;
    res_q    <= res_d;
  end

  assign hi_ext  = {{2{p_hi_q[63]}}, p_hi_q, 32'd0};
  assign lo_ext  = {{33{p_lo_q[64]}}, p_lo_q};
  assign off_ext = {{50{offset_q[47]}}, offset_q};
  assign sum     = hi_ext + lo_ext + off_ext;

  assign sum_fits = (~|sum[97:63]) || (&sum[97:63]);

  always_comb begin
    res_d.raw_value    = raw_q;
    res_d.out_of_frame = oof_q;
    res_d.saturated    = !sum_fits;
    if (sum_fits) begin
      res_d.phys_value = sum[63:0];
    end else begin
      res_d.phys_value = sum[97] ? MinVal : MaxVal;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* src/can_signal_unpack_core.sv */
// ----------------------------------------------------------------------------
// can_signal_unpack_core: CAN signal decoder
// Extracts one signal from a CAN payload and scales it to a physical value.
// ----------------------------------------------------------------------------
// A command beat is taken on any clock edge where start is high; busy never
// rises, so one signal can be issued every clock. Each result appears on
// result_o for exactly one cycle, flagged by done_o, in issue order. The
// receiver cannot stall the block: a result not captured in its done_o cycle
// is gone. Between command beat and result lie the command register, the
// bit extraction register, the registered partial products of the 32-bit
// halves of raw times factor, then the offset add and saturation register.
module can_signal_unpack_core #(
  parameter int unsigned FRAME_BYTES = csu_pkg::FRAME_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  csu_pkg::item_t   item_i,
  output logic             done_o,
  output csu_pkg::result_t result_o
);

  logic              accept;
  logic              cmd_valid_q;
  csu_pkg::item_t    cmd_q;
  csu_pkg::extract_t ext_d, ext_q;
  logic              ext_valid_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      ext_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= accept;
      ext_valid_q <= cmd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= item_i;
    ext_q <= ext_d;
  end

  csu_extract #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_extract (
    .item_i(cmd_q),
    .ext_o (ext_d)
  );

  csu_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(ext_valid_q),
    .ext_i  (ext_q),
    .valid_o(done_o),
    .res_o  (result_o)
  );

  a_done_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("done without a command beat four cycles earlier");

  a_cmd_gets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_o)
    else $error("command beat lost in pipeline");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.saturated) |->
      (result_o.phys_value == {1'b0, {63{1'b1}}} || result_o.phys_value == {1'b1, 63'd0}))
    else $error("saturated result is not a range limit");

  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(accept && item_i.length == 7'd0, 4)) |->
      (result_o.raw_value == 64'd0 && !result_o.out_of_frame))
    else $error("zero-length signal produced bits");

endmodule
